>>> rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the software timer table
// Entry layout, operation, kind and status codes, and the controller to
// datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

   localparam int POOL_ENTRIES = 16;
   localparam int IDX_W        = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int CNT_W        = $clog2(POOL_ENTRIES + 1);
   localparam int FREE_W       = 5;

   localparam logic [1:0] OP_SET    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_EXPIRY = 2'd1;
   localparam logic [1:0] KIND_NONE   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic [7:0]  task_id;
      logic [7:0]  signal_code;
      logic [31:0] remaining;
      logic [31:0] period;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic scan;
      logic apply;
      logic reply;
      logic count;
      logic count_end;
      logic rotate;
      logic noexp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       req_valid;
      logic [1:0] operation;
      logic       scan_done;
      logic       cnt_done;
      logic       head_expired;
      logic       out_free;
      logic       any_exp;
   } stat_type;

   // remaining count after a tick, floored at zero
   function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
      sat_sub = (a > b) ? (a - b) : 32'd0;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/stt_if.sv
// ----------------------------------------------------------------------------
// stt_if: request and response channels of the software timer table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [7:0]  task_id;
   logic [7:0]  signal_code;
   logic [31:0] duration;
   logic        periodic;
   logic [31:0] elapsed;

   modport source (output valid, operation, task_id, signal_code, duration,
                   periodic, elapsed, input ready);
   modport sink (input valid, operation, task_id, signal_code, duration,
                 periodic, elapsed, output ready);
endinterface

interface stt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [1:0] status;
   logic [7:0] expired_task;
   logic [7:0] expired_signal;
   logic       last;
   logic [4:0] free_entries;

   modport source (output valid, kind, status, expired_task, expired_signal,
                   last, free_entries, input ready);
   modport sink (input valid, kind, status, expired_task, expired_signal,
                 last, free_entries, output ready);
endinterface

`default_nettype wire

>>> rtl/core/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl: operation sequencer of the software timer table
// Walks set and remove through key scan and table update, ticks through a
// count pass and a rotate pass; response beats wait for the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_ctrl
   import stt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCAN   = 7'b0000010,
      S_APPLY  = 7'b0000100,
      S_REPLY  = 7'b0001000,
      S_COUNT  = 7'b0010000,
      S_ROTATE = 7'b0100000,
      S_NOEXP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.take = 1'b1;
            if (stat.req_valid) begin
               case (stat.operation)
                  OP_SET, OP_REMOVE: state_in = S_SCAN;
                  OP_TICK:           state_in = S_COUNT;
                  default:           state_in = S_REPLY;
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_REPLY;
         end
         S_REPLY: begin
            if (stat.out_free) begin
               cmd.reply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_COUNT: begin
            if (stat.cnt_done) begin
               cmd.count_end = 1'b1;
               state_in      = S_ROTATE;
            end else begin
               cmd.count = 1'b1;
            end
         end
         S_ROTATE: begin
            if (stat.cnt_done) begin
               state_in = stat.any_exp ? S_IDLE : S_NOEXP;
            end else if (!stat.head_expired || stat.out_free) begin
               cmd.rotate = 1'b1;
            end
         end
         S_NOEXP: begin
            if (stat.out_free) begin
               cmd.noexp = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a request is taken only from idle, never twice in a row
   a_take_once: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && stat.req_valid) |=> !cmd.take)
      else $error("request taken while busy");

   // a reply beat is only issued into a free output register
   a_reply_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.reply || cmd.noexp) |-> stat.out_free)
      else $error("reply issued into full output register");

   // an expiring rotate step only runs when the beat can be written
   a_rot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.rotate && stat.head_expired) |-> stat.out_free)
      else $error("expiry beat dropped");

endmodule

`default_nettype wire

>>> rtl/core/stt_datapath.sv
// ----------------------------------------------------------------------------
// stt_datapath: timer list storage, scan counters and response register
// Entries are kept packed in age order, newest at position zero. A tick
// first counts expiries, then rotates the list once through its head.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_datapath
   import stt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   stt_req_if.sink      req_chan,
   stt_rsp_if.source    rsp_chan,
   input  cmd_type      cmd,
   output stat_type     stat
);

   entry_type            ent_ff [POOL_ENTRIES];
   entry_type            ent_in [POOL_ENTRIES];
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     tick_n_ff, tick_n_in;
   logic [CNT_W-1:0]     rm_cnt_ff, rm_cnt_in;
   logic [CNT_W-1:0]     last_pos_ff, last_pos_in;
   logic                 any_exp_ff, any_exp_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     match_ff, match_in;
   logic [1:0]           st_ff, st_in;

   logic [1:0]           op_ff;
   logic [7:0]           task_ff;
   logic [7:0]           sig_ff;
   logic [31:0]          dur_ff;
   logic                 per_ff;
   logic [31:0]          el_ff;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_kind_ff;
   logic [1:0]           rsp_status_ff;
   logic [7:0]           rsp_task_ff;
   logic [7:0]           rsp_sig_ff;
   logic                 rsp_last_ff;
   logic [FREE_W-1:0]    rsp_free_ff;

   entry_type            cur;
   entry_type            head;
   entry_type            head_upd;
   logic [31:0]          cur_rem;
   logic [31:0]          head_rem;
   logic                 at_end;
   logic                 hit;
   logic                 head_exp;
   logic                 head_keep;
   logic                 out_free;
   logic                 accept;
   logic [CNT_W-1:0]     free_now;
   logic [CNT_W-1:0]     free_tick;

   assign accept   = cmd.take && req_chan.valid;
   assign req_chan.ready = cmd.take;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // entry under scan and the list head
   assign cur      = ent_ff[idx_ff[IDX_W-1:0]];
   assign head     = ent_ff[0];
   assign cur_rem  = sat_sub(cur.remaining, el_ff);
   assign head_rem = sat_sub(head.remaining, el_ff);
   assign at_end   = (idx_ff == n_ff);
   assign hit      = !at_end && (cur.task_id == task_ff) && (cur.signal_code == sig_ff);
   assign head_exp = (head_rem == 32'd0);
   assign head_keep = !head_exp || (head.period != 32'd0);

   always_comb begin
      head_upd           = head;
      head_upd.remaining = head_exp ? head.period : head_rem;
   end

   assign free_now  = CNT_W'(POOL_ENTRIES) - n_ff;
   assign free_tick = CNT_W'(POOL_ENTRIES) - (tick_n_ff - rm_cnt_ff);

   // status to the controller
   always_comb begin
      stat.req_valid    = req_chan.valid;
      stat.operation    = req_chan.operation;
      stat.scan_done    = at_end || hit;
      stat.cnt_done     = (idx_ff == tick_n_ff);
      stat.head_expired = head_exp;
      stat.out_free     = out_free;
      stat.any_exp      = any_exp_ff;
   end

   // list and counter updates
   always_comb begin
      ent_in      = ent_ff;
      n_in        = n_ff;
      idx_in      = idx_ff;
      tick_n_in   = tick_n_ff;
      rm_cnt_in   = rm_cnt_ff;
      last_pos_in = last_pos_ff;
      any_exp_in  = any_exp_ff;
      found_in    = found_ff;
      match_in    = match_ff;
      st_in       = st_ff;

      if (accept) begin
         idx_in      = '0;
         tick_n_in   = n_ff;
         rm_cnt_in   = '0;
         last_pos_in = '0;
         any_exp_in  = 1'b0;
         found_in    = 1'b0;
         st_in       = ST_OK;
      end

      // key search, one entry per cycle
      if (cmd.scan) begin
         if (hit) begin
            found_in = 1'b1;
            match_in = idx_ff[IDX_W-1:0];
         end else if (!at_end) begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end

      // set or remove on the located entry; a set with no match inserts at the head
      if (cmd.apply) begin
         if (op_ff == OP_SET) begin
            if (found_ff) begin
               ent_in[match_ff].remaining = dur_ff;
            end else if (n_ff < CNT_W'(POOL_ENTRIES)) begin
               for (int i = POOL_ENTRIES - 1; i > 0; i--) begin
                  ent_in[i] = ent_ff[i-1];
               end
               ent_in[0].task_id     = task_ff;
               ent_in[0].signal_code = sig_ff;
               ent_in[0].remaining   = dur_ff;
               ent_in[0].period      = per_ff ? dur_ff : 32'd0;
               n_in = n_ff + CNT_W'(1);
            end else begin
               st_in = ST_FULL;
            end
         end else begin
            if (found_ff) begin
               for (int i = 0; i < POOL_ENTRIES - 1; i++) begin
                  if (IDX_W'(i) >= match_ff) ent_in[i] = ent_ff[i+1];
               end
               n_in = n_ff - CNT_W'(1);
            end else begin
               st_in = ST_NOT_FOUND;
            end
         end
      end

      // tick pass one: count expiries and removals
      if (cmd.count) begin
         if (cur_rem == 32'd0) begin
            any_exp_in  = 1'b1;
            last_pos_in = idx_ff;
            if (cur.period == 32'd0) rm_cnt_in = rm_cnt_ff + CNT_W'(1);
         end
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.count_end) begin
         idx_in = '0;
      end

      // tick pass two: pop the head, append it again unless freed
      if (cmd.rotate) begin
         for (int i = 0; i < POOL_ENTRIES - 1; i++) begin
            ent_in[i] = ent_ff[i+1];
         end
         if (head_keep) begin
            ent_in[IDX_W'(n_ff - CNT_W'(1))] = head_upd;
         end else begin
            n_in = n_ff - CNT_W'(1);
         end
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      ent_ff      <= ent_in;
      idx_ff      <= idx_in;
      last_pos_ff <= last_pos_in;
      any_exp_ff  <= any_exp_in;
      found_ff    <= found_in;
      match_ff    <= match_in;
      st_ff       <= st_in;
      if (accept) begin
         op_ff   <= req_chan.operation;
         task_ff <= req_chan.task_id;
         sig_ff  <= req_chan.signal_code;
         dur_ff  <= req_chan.duration;
         per_ff  <= req_chan.periodic;
         el_ff   <= req_chan.elapsed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff      <= '0;
         tick_n_ff <= '0;
         rm_cnt_ff <= '0;
      end else begin
         n_ff      <= n_in;
         tick_n_ff <= tick_n_in;
         rm_cnt_ff <= rm_cnt_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.reply || cmd.noexp || (cmd.rotate && head_exp)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply || cmd.noexp) begin
         rsp_kind_ff   <= cmd.reply ? KIND_STATUS : KIND_NONE;
         rsp_status_ff <= cmd.reply ? st_ff : ST_OK;
         rsp_task_ff   <= '0;
         rsp_sig_ff    <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_free_ff   <= FREE_W'(free_now);
      end else if (cmd.rotate && head_exp) begin
         rsp_kind_ff   <= KIND_EXPIRY;
         rsp_status_ff <= ST_OK;
         rsp_task_ff   <= head.task_id;
         rsp_sig_ff    <= head.signal_code;
         rsp_last_ff   <= (idx_ff == last_pos_ff);
         rsp_free_ff   <= FREE_W'(free_tick);
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.kind           = rsp_kind_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.expired_task   = rsp_task_ff;
   assign rsp_chan.expired_signal = rsp_sig_ff;
   assign rsp_chan.last           = rsp_last_ff;
   assign rsp_chan.free_entries   = rsp_free_ff;

   // the list never holds more entries than the pool
   a_fill: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(POOL_ENTRIES))
      else $error("entry count beyond pool size");

   // removals counted in pass one never exceed the entries seen
   a_rm: assert property (@(posedge clock) disable iff (reset)
      rm_cnt_ff <= tick_n_ff)
      else $error("removal count beyond tick population");

   // a rotate step never runs on an empty list
   a_rot: assert property (@(posedge clock) disable iff (reset)
      cmd.rotate |-> (n_ff != '0))
      else $error("rotate on empty list");

endmodule

`default_nettype wire

>>> rtl/core/software_timer_table.sv
// ----------------------------------------------------------------------------
// software_timer_table: table of one-shot and periodic software timers
// Requests arrive on req_chan (set, remove, tick), results leave on rsp_chan.
// Set and remove give one status beat; a tick gives one expiry beat per
// expired timer, newest first, or one idle beat, with last on the final one.
// Set and remove scan the list one entry per cycle until the key is found or
// the list ends, then update the list and reply. A tick takes a count pass
// and then a rotate pass over the live timers. One request is in flight at a
// time; req_chan.ready is high only while the block is idle.
// Reset clears the live count; the table is then empty and all 16 entries
// free. When rsp_chan stalls, the held beat stays put and the sequencer
// waits before writing the next one; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_table
   import stt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   stt_req_if.sink    req_chan,
   stt_rsp_if.source  rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   stt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // timer list and response register
   stt_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule

`default_nettype wire
